// ----- hdl/exyz_pkg.sv -----
// Package for the Euler XYZ point rotation pipeline.
// Holds the formats, the CORDIC arctangent table and the rounding helpers.
// No dependencies.
package exyz_pkg;

    localparam int COORD_WIDTH    = 32;
    localparam int ANGLE_WIDTH    = 16;
    localparam int TRIG_FRAC_BITS = 15;
    localparam int CORDIC_STEPS   = 30;
    localparam int CORDIC_FRAC    = 30;

    // widths: CORDIC datapath, internal coordinate, trig value, trig magnitude, product
    localparam int XW = CORDIC_FRAC + 3;
    localparam int ZW = 33;
    localparam int IW = COORD_WIDTH + 4;
    localparam int TW = TRIG_FRAC_BITS + 2;
    localparam int MW = TRIG_FRAC_BITS + 1;
    localparam int PW = IW + MW;
    localparam int SH = CORDIC_FRAC - TRIG_FRAC_BITS;

    // stream layout
    localparam int IN_W   = 3 * COORD_WIDTH + 3 * ANGLE_WIDTH;
    localparam int IN_TW  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W  = 3 * COORD_WIDTH;
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

    // pipeline map: prep, CORDIC steps, trig rounding, three rotations of two stages each
    localparam int TRIG_ST = CORDIC_STEPS + 1;
    localparam int ROT_ST  = TRIG_ST + 1;
    localparam int NST     = ROT_ST + 6;

    localparam logic signed [XW-1:0] CORDIC_GAIN = XW'(652032874);
    localparam logic signed [XW-1:0] TRIG_HALF   = XW'(1) << (SH - 1);
    localparam logic signed [XW-1:0] TRIG_LIM    = XW'(1) << TRIG_FRAC_BITS;
    localparam logic [PW-1:0]        PROD_HALF   = PW'(1) << (TRIG_FRAC_BITS - 1);
    localparam logic signed [IW-1:0] SAT_HI      = (IW'(1) << (COORD_WIDTH - 1)) - IW'(1);
    localparam logic signed [IW-1:0] SAT_LO      = ~SAT_HI;

    localparam logic signed [ZW-1:0] ATAN_TURN32 [0:CORDIC_STEPS-1] = '{
        ZW'('h20000000), ZW'('h12E4051E), ZW'('h09FB385B), ZW'('h051111D4), ZW'('h028B0D43),
        ZW'('h0145D7E1), ZW'('h00A2F61E), ZW'('h00517C55), ZW'('h0028BE53), ZW'('h00145F2F),
        ZW'('h000A2F98), ZW'('h000517CC), ZW'('h00028BE6), ZW'('h000145F3), ZW'('h0000A2FA),
        ZW'('h0000517D), ZW'('h000028BE), ZW'('h0000145F), ZW'('h00000A30), ZW'('h00000518),
        ZW'('h0000028C), ZW'('h00000146), ZW'('h000000A3), ZW'('h00000051), ZW'('h00000029),
        ZW'('h00000014), ZW'('h0000000A), ZW'('h00000005), ZW'('h00000003), ZW'('h00000001)
    };

    function automatic logic signed [TW-1:0] trig_round(logic signed [XW-1:0] v, logic fl);
        logic signed [XW-1:0] t;
        logic signed [TW-1:0] r;
        t = (v + TRIG_HALF) >>> SH;
        if (t > TRIG_LIM) t = TRIG_LIM;
        if (t < -TRIG_LIM) t = -TRIG_LIM;
        r = TW'(t);
        return fl ? -r : r;
    endfunction

    function automatic logic [PW-1:0] prod_mag(logic signed [IW-1:0] a, logic signed [TW-1:0] t);
        logic [IW-1:0] ua;
        logic [TW-1:0] ut;
        ua = a[IW-1] ? IW'(-a) : IW'(a);
        ut = t[TW-1] ? TW'(-t) : TW'(t);
        return PW'(ua) * PW'(ut[MW-1:0]);
    endfunction

    function automatic logic signed [IW-1:0] prod_fin(logic [PW-1:0] p, logic sg);
        logic [PW-1:0]        m;
        logic signed [IW-1:0] s;
        m = (p + PROD_HALF) >> TRIG_FRAC_BITS;
        s = IW'(m);
        return sg ? -s : s;
    endfunction

endpackage

// ----- hdl/euler_xyz_point_rotation.sv -----
// Euler XYZ point rotation: a 30-stage CORDIC pipeline (three lanes) followed by trig
// rounding, three two-stage rotations and saturation; one transaction per cycle sustained
// while the output is accepted (s_tready drops while the skid entry is full).
// A one-entry skid buffer behind the output register keeps s_tready registered.
// Synchronous active-low reset clears all valid bits; payload registers are not reset.
module euler_xyz_point_rotation import exyz_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    // point_x, point_y, point_z, angle_x, angle_y, angle_z
    input  logic [IN_TW-1:0]  s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    // rotated_x, rotated_y, rotated_z
    output logic [OUT_TW-1:0] m_tdata,
    // clipped
    output logic              m_tuser
);

    logic [NST-1:0] r_v;
    logic           w_adv;

    logic signed [IW-1:0] r_px [0:NST-1];
    logic signed [IW-1:0] r_py [0:NST-1];
    logic signed [IW-1:0] r_pz [0:NST-1];

    logic signed [XW-1:0] r_cx [0:CORDIC_STEPS][0:2];
    logic signed [XW-1:0] r_cy [0:CORDIC_STEPS][0:2];
    logic signed [ZW-1:0] r_cz [0:CORDIC_STEPS][0:2];
    logic [2:0]           r_fl [0:CORDIC_STEPS];

    logic signed [TW-1:0] r_cos [TRIG_ST:NST-1][0:2];
    logic signed [TW-1:0] r_sin [TRIG_ST:NST-1][0:2];

    logic [PW-1:0] r_pr [0:2][0:3];
    logic [3:0]    r_sg [0:2];

    logic                   r_ov, r_kv, r_oc, r_kc;
    logic [OUT_W-1:0]       r_od, r_kd;
    logic [OUT_W-1:0]       w_d;
    logic                   w_c;
    logic                   w_in;

    assign w_adv    = !r_kv;
    assign s_tready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_adv) begin
            r_v <= {r_v[NST-2:0], s_tvalid};
        end
    end

    // stage 0: point widening, quadrant fold of the angles
    genvar k, i, r, s;
    generate
        for (k = 0; k < 3; k++) begin : g_prep
            logic [31:0] w_a;
            logic        w_f;
            assign w_a = {s_tdata[3*COORD_WIDTH + k*ANGLE_WIDTH +: ANGLE_WIDTH],
                          {(32-ANGLE_WIDTH){1'b0}}};
            assign w_f = w_a[31] ^ w_a[30];
            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    r_cx[0][k] <= CORDIC_GAIN;
                    r_cy[0][k] <= '0;
                    r_cz[0][k] <= {{(ZW-31){w_a[31] ^ w_f}}, w_a[30:0]};
                    r_fl[0][k] <= w_f;
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_px[0] <= IW'($signed(s_tdata[0 +: COORD_WIDTH]));
            r_py[0] <= IW'($signed(s_tdata[COORD_WIDTH +: COORD_WIDTH]));
            r_pz[0] <= IW'($signed(s_tdata[2*COORD_WIDTH +: COORD_WIDTH]));
        end
    end

    // CORDIC steps
    generate
        for (i = 0; i < CORDIC_STEPS; i++) begin : g_step
            for (k = 0; k < 3; k++) begin : g_lane
                always_ff @(posedge i_clk) begin
                    if (w_adv) begin
                        if (!r_cz[i][k][ZW-1]) begin
                            r_cx[i+1][k] <= r_cx[i][k] - (r_cy[i][k] >>> i);
                            r_cy[i+1][k] <= r_cy[i][k] + (r_cx[i][k] >>> i);
                            r_cz[i+1][k] <= r_cz[i][k] - ATAN_TURN32[i];
                        end else begin
                            r_cx[i+1][k] <= r_cx[i][k] + (r_cy[i][k] >>> i);
                            r_cy[i+1][k] <= r_cy[i][k] - (r_cx[i][k] >>> i);
                            r_cz[i+1][k] <= r_cz[i][k] + ATAN_TURN32[i];
                        end
                    end
                end
            end
            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    r_fl[i+1] <= r_fl[i];
                end
            end
        end
        for (s = 1; s <= TRIG_ST; s++) begin : g_pass
            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    r_px[s] <= r_px[s-1];
                    r_py[s] <= r_py[s-1];
                    r_pz[s] <= r_pz[s-1];
                end
            end
        end
    endgenerate

    // trig rounding, then trig values ride along
    generate
        for (k = 0; k < 3; k++) begin : g_trig
            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    r_cos[TRIG_ST][k] <= trig_round(r_cx[CORDIC_STEPS][k],
                                                    r_fl[CORDIC_STEPS][k]);
                    r_sin[TRIG_ST][k] <= trig_round(r_cy[CORDIC_STEPS][k],
                                                    r_fl[CORDIC_STEPS][k]);
                end
            end
        end
        for (s = ROT_ST; s < NST; s++) begin : g_tpass
            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    r_cos[s] <= r_cos[s-1];
                    r_sin[s] <= r_sin[s-1];
                end
            end
        end
    endgenerate

    // rotations Z, Y, X: u' = uc - vs, v' = us + vc
    generate
        for (r = 0; r < 3; r++) begin : g_rot
            localparam int MS = ROT_ST + 2*r;
            localparam int TK = 2 - r;
            logic signed [IW-1:0] w_u, w_v;
            logic signed [TW-1:0] w_c0, w_s0;
            logic signed [IW-1:0] w_un, w_vn;
            if (r == 0) begin : g_z
                assign w_u = r_px[MS-1];
                assign w_v = r_py[MS-1];
            end else if (r == 1) begin : g_y
                assign w_u = r_pz[MS-1];
                assign w_v = r_px[MS-1];
            end else begin : g_x
                assign w_u = r_py[MS-1];
                assign w_v = r_pz[MS-1];
            end
            assign w_c0 = r_cos[MS-1][TK];
            assign w_s0 = r_sin[MS-1][TK];

            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    r_pr[r][0] <= prod_mag(w_u, w_c0);
                    r_pr[r][1] <= prod_mag(w_v, w_s0);
                    r_pr[r][2] <= prod_mag(w_u, w_s0);
                    r_pr[r][3] <= prod_mag(w_v, w_c0);
                    r_sg[r]    <= {w_v[IW-1] ^ w_c0[TW-1], w_u[IW-1] ^ w_s0[TW-1],
                                   w_v[IW-1] ^ w_s0[TW-1], w_u[IW-1] ^ w_c0[TW-1]};
                    r_px[MS]   <= r_px[MS-1];
                    r_py[MS]   <= r_py[MS-1];
                    r_pz[MS]   <= r_pz[MS-1];
                end
            end

            assign w_un = prod_fin(r_pr[r][0], r_sg[r][0]) - prod_fin(r_pr[r][1], r_sg[r][1]);
            assign w_vn = prod_fin(r_pr[r][2], r_sg[r][2]) + prod_fin(r_pr[r][3], r_sg[r][3]);

            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    if (r == 0) begin
                        r_px[MS+1] <= w_un;
                        r_py[MS+1] <= w_vn;
                        r_pz[MS+1] <= r_pz[MS];
                    end else if (r == 1) begin
                        r_pz[MS+1] <= w_un;
                        r_px[MS+1] <= w_vn;
                        r_py[MS+1] <= r_py[MS];
                    end else begin
                        r_py[MS+1] <= w_un;
                        r_pz[MS+1] <= w_vn;
                        r_px[MS+1] <= r_px[MS];
                    end
                end
            end
        end
    endgenerate

    // saturation
    always_comb begin
        logic signed [IW-1:0] q [0:2];
        logic [COORD_WIDTH-1:0] o [0:2];
        q[0] = r_px[NST-1];
        q[1] = r_py[NST-1];
        q[2] = r_pz[NST-1];
        w_c = 1'b0;
        for (int j = 0; j < 3; j++) begin
            if (q[j] > SAT_HI) begin
                o[j] = SAT_HI[COORD_WIDTH-1:0];
                w_c  = 1'b1;
            end else if (q[j] < SAT_LO) begin
                o[j] = SAT_LO[COORD_WIDTH-1:0];
                w_c  = 1'b1;
            end else begin
                o[j] = q[j][COORD_WIDTH-1:0];
            end
        end
        w_d = {o[2], o[1], o[0]};
    end

    assign w_in = w_adv & r_v[NST-1];

    // output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_kv <= 1'b0;
        end else if (!r_ov || m_tready) begin
            r_ov <= r_kv | w_in;
            r_kv <= 1'b0;
        end else if (w_in) begin
            r_kv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ov || m_tready) begin
            r_od <= r_kv ? r_kd : w_d;
            r_oc <= r_kv ? r_kc : w_c;
        end else if (w_in) begin
            r_kd <= w_d;
            r_kc <= w_c;
        end
    end

    assign m_tvalid = r_ov;
    assign m_tdata  = OUT_TW'(r_od);
    assign m_tuser  = r_oc;

endmodule

// ----- bench/tb_euler_xyz_point_rotation.sv -----
// Testbench for the Euler XYZ point rotation pipeline: directed and random points
// and angles, results predicted bit for bit by an in-bench CORDIC and rotation model.
// Depends on exyz_pkg and euler_xyz_point_rotation.
`timescale 1ns / 100ps

module tb_euler_xyz_point_rotation import exyz_pkg::*; ();

    typedef struct packed {
        logic [COORD_WIDTH-1:0] x;
        logic [COORD_WIDTH-1:0] y;
        logic [COORD_WIDTH-1:0] z;
        logic                   clip;
    } rot_t;

    localparam int WATCHDOG = 20000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_TW-1:0]  s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_TW-1:0] m_tdata;
    logic              m_tuser;

    rot_t   rot_q[$];
    int     errs = 0;
    int     quiet = 0;
    int     hold = 0;
    bit     calm = 1'b0;
    bit     rx_on = 1'b0;

    // CORDIC arctangents, 2^32 per turn
    longint atan_lut[30] = '{
        'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43,
        'h0145D7E1, 'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F,
        'h000A2F98, 'h000517CC, 'h00028BE6, 'h000145F3, 'h0000A2FA,
        'h0000517D, 'h000028BE, 'h0000145F, 'h00000A30, 'h00000518,
        'h0000028C, 'h00000146, 'h000000A3, 'h00000051, 'h00000029,
        'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001
    };

    euler_xyz_point_rotation dut (.*);

    always #5 i_clk = ~i_clk;

    task automatic calc_sincos(input logic [ANGLE_WIDTH-1:0] ang, output longint sn,
                               output longint cs);
        longint lim, cx, cy, cz, nx;
        logic [31:0] a;
        bit flip;
        a = {ang, {(32-ANGLE_WIDTH){1'b0}}};
        flip = (a[31:30] == 2'd1 || a[31:30] == 2'd2);
        if (flip) a = a + 32'h80000000;
        cz = longint'($signed(a));
        cx = 652032874;
        cy = 0;
        for (int i = 0; i < 30; i++) begin
            if (cz >= 0) begin
                nx = cx - (cy >>> i);
                cy = cy + (cx >>> i);
                cz -= atan_lut[i];
            end else begin
                nx = cx + (cy >>> i);
                cy = cy - (cx >>> i);
                cz += atan_lut[i];
            end
            cx = nx;
        end
        lim = longint'(1) << TRIG_FRAC_BITS;
        cx = (cx + (longint'(1) << (SH - 1))) >>> SH;
        cy = (cy + (longint'(1) << (SH - 1))) >>> SH;
        if (cx > lim) cx = lim;
        if (cx < -lim) cx = -lim;
        if (cy > lim) cy = lim;
        if (cy < -lim) cy = -lim;
        cs = flip ? -cx : cx;
        sn = flip ? -cy : cy;
    endtask

    function automatic longint frac_mul(longint a, longint t);
        longint ua, ut, m;
        ua = (a < 0) ? -a : a;
        ut = (t < 0) ? -t : t;
        m = (ua >> TRIG_FRAC_BITS) * ut
          + (((ua & ((longint'(1) << TRIG_FRAC_BITS) - 1)) * ut
              + (longint'(1) << (TRIG_FRAC_BITS - 1))) >> TRIG_FRAC_BITS);
        return ((a < 0) != (t < 0)) ? -m : m;
    endfunction

    function automatic logic [COORD_WIDTH-1:0] clamp_coord(longint v, inout logic clip);
        longint hi, lo;
        hi = (longint'(1) << (COORD_WIDTH - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin v = hi; clip = 1'b1; end
        if (v < lo) begin v = lo; clip = 1'b1; end
        return v[COORD_WIDTH-1:0];
    endfunction

    task automatic predict_rotation(input logic [IN_TW-1:0] d);
        longint px, py, pz, sx, cx, sy, cy, sz, cz, nx, ny, nz;
        rot_t r;
        px = longint'($signed(d[COORD_WIDTH-1:0]));
        py = longint'($signed(d[2*COORD_WIDTH-1 -: COORD_WIDTH]));
        pz = longint'($signed(d[3*COORD_WIDTH-1 -: COORD_WIDTH]));
        calc_sincos(d[3*COORD_WIDTH +: ANGLE_WIDTH], sx, cx);
        calc_sincos(d[3*COORD_WIDTH+ANGLE_WIDTH +: ANGLE_WIDTH], sy, cy);
        calc_sincos(d[3*COORD_WIDTH+2*ANGLE_WIDTH +: ANGLE_WIDTH], sz, cz);
        nx = frac_mul(px, cz) - frac_mul(py, sz);
        ny = frac_mul(px, sz) + frac_mul(py, cz);
        px = nx; py = ny;
        nx = frac_mul(px, cy) + frac_mul(pz, sy);
        nz = frac_mul(pz, cy) - frac_mul(px, sy);
        px = nx; pz = nz;
        ny = frac_mul(py, cx) - frac_mul(pz, sx);
        nz = frac_mul(py, sx) + frac_mul(pz, cx);
        r.clip = 1'b0;
        r.x = clamp_coord(px, r.clip);
        r.y = clamp_coord(ny, r.clip);
        r.z = clamp_coord(nz, r.clip);
        rot_q = {rot_q, r};
    endtask

    task automatic send_point(input logic [31:0] x, y, z, input logic [15:0] ax, ay, az);
        logic [IN_TW-1:0] d;
        int gap;
        if (!calm && $urandom_range(3) == 0) begin
            gap = $urandom_range(1, 5);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        d = '0;
        d[3*COORD_WIDTH+3*ANGLE_WIDTH-1:0] = {az, ay, ax, z, y, x};
        s_tdata  <= d;
        s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        predict_rotation(d);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(4))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 'h3FFFF)) - 'h20000);
            2: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
            default: return 32'($signed($urandom) >>> $urandom_range(0, 16));
        endcase
    endfunction

    task automatic test_extremes();
        logic [31:0] c[6] = '{32'h0, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF,
                              32'h00010000, 32'hFFFF0000};
        foreach (c[i]) send_point(c[i], c[(i+1)%6], c[(i+2)%6], 16'h0, 16'h0, 16'h0);
        send_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'h2000, 16'h2000, 16'h2000);
        send_point(32'h80000000, 32'h80000000, 32'h80000000, 16'hE000, 16'h6000, 16'hA000);
        send_point(32'hFFFFFFFF, 32'h0, 32'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    endtask

    task automatic test_quadrants();
        logic [15:0] a[8] = '{16'h4000, 16'h8000, 16'hC000, 16'h3FFF,
                              16'h4001, 16'h7FFF, 16'hBFFF, 16'h0001};
        foreach (a[i]) send_point(32'h00010000, 32'h00020000, 32'hFFFD0000,
                                  a[i], a[(i+3)%8], a[(i+5)%8]);
    endtask

    task automatic test_random(input int n);
        for (int i = 0; i < n; i++)
            send_point(rand_coord(), rand_coord(), rand_coord(),
                       16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // result sink with back-pressure in bursts
    always @(posedge i_clk) begin
        rot_t got, want;
        if (rx_on) begin
            if (m_tvalid && m_tready) begin
                got = '{x: m_tdata[31:0], y: m_tdata[63:32], z: m_tdata[95:64],
                        clip: m_tuser};
                if (rot_q.size() == 0) begin
                    $display("%0t: result with none expected: %h", $time, got);
                    errs++;
                end else begin
                    want = rot_q.pop_front();
                    if (got.x !== want.x) begin
                        $display("%0t: x exp %h got %h", $time, want.x, got.x); errs++;
                    end
                    if (got.y !== want.y) begin
                        $display("%0t: y exp %h got %h", $time, want.y, got.y); errs++;
                    end
                    if (got.z !== want.z) begin
                        $display("%0t: z exp %h got %h", $time, want.z, got.z); errs++;
                    end
                    if (got.clip !== want.clip) begin
                        $display("%0t: clip exp %b got %b", $time, want.clip, got.clip);
                        errs++;
                    end
                end
            end
            if (hold != 0) begin
                m_tready <= 1'b0;
                hold <= hold - 1;
            end else if (m_tready && !calm && $urandom_range(3) == 0) begin
                m_tready <= 1'b0;
                hold <= $urandom_range(0, 4);
            end else begin
                m_tready <= 1'b1;
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
            else quiet <= quiet + 1;
            if (quiet >= WATCHDOG) begin
                $display("tb_euler_xyz_point_rotation: errors");
                $finish;
            end
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        rx_on <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_quadrants();
        test_random(1000);
        calm = 1'b1;
        test_random(230);
        s_tvalid <= 1'b0;
        while (rot_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errs == 0)
            $display("tb_euler_xyz_point_rotation: clean");
        else
            $display("tb_euler_xyz_point_rotation: errors");
        $finish;
    end

endmodule
